[hw/rtl/nrtb_pkg.sv]
// Package for the named reload timer bank: types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package nrtb_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FIRED     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_TICK_RD,
    S_TICK_EVAL,
    S_TICK_END
  } state_e;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] current;
    logic signed [31:0] start;
    logic signed [31:0] target;
    logic               down;
    logic               enabled;
    logic               one_shot;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic emit_hit;
    logic miss;
    logic tick_eval;
    logic tick_end;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic more;
  } sts_t;

endpackage

[hw/rtl/nrtb_ctrl.sv]
// Sequencer of the timer bank: walks the table for searches and ticks.
// Depends on nrtb_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
module nrtb_ctrl import nrtb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] kind_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (kind_e'(kind_i))
            KIND_ADD, KIND_QUERY: state_d = sts_i.cnt_zero ? S_MISS : S_SCAN_RD;
            KIND_TICK:            state_d = sts_i.cnt_zero ? S_TICK_END : S_TICK_RD;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.hit) begin
          cmd_o.emit_hit = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = sts_i.more ? S_SCAN_RD : S_MISS;
        end
      end
      S_MISS: begin
        cmd_o.miss = 1'b1;
        state_d    = S_IDLE;
      end
      S_TICK_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_TICK_EVAL;
      end
      S_TICK_EVAL: begin
        cmd_o.tick_eval = 1'b1;
        cmd_o.step      = 1'b1;
        state_d         = sts_i.more ? S_TICK_RD : S_TICK_END;
      end
      S_TICK_END: begin
        cmd_o.tick_end = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/nrtb_datapath.sv]
// Datapath of the timer bank: entry memory, item registers, tick arithmetic
// and the result register. Depends on nrtb_pkg; commanded by nrtb_ctrl.
`timescale 1ns / 1ps
module nrtb_datapath import nrtb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        timer_id_i,
  input  logic signed [31:0] initial_value_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] target_value_i,
  input  logic               count_down_i,
  input  logic               enabled_i,
  input  logic               one_shot_i,
  input  logic [30:0]        delta_i,
  output logic               valid_o,
  output logic [2:0]         status_o,
  output logic [15:0]        result_id_o,
  output logic signed [31:0] result_current_o,
  output logic signed [31:0] result_start_o,
  output logic signed [31:0] result_target_o,
  output logic               result_down_o,
  output logic               result_enabled_o,
  output logic               result_one_shot_o,
  output logic               last_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  entry_t mem [SLOTS];
  entry_t rdata_q;
  entry_t item_q;
  entry_t pend_q, pend_d;
  kind_e  kind_q;
  logic [30:0] delta_q;
  logic [CNT_W-1:0] count_q, rd_idx_q, wr_idx_q;
  logic [FIRE_W-1:0] fire_cnt_q;
  logic pend_vld_q;
  logic out_vld_q;
  logic full;

  // Write port.
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  // Tick arithmetic on the entry just read.
  logic signed [33:0] cur_x, del_x, sum_x, diff_x;
  logic signed [31:0] up_c, dn_c, new_c;
  logic               fired, report;
  entry_t             tick_e;

  // Result to be registered.
  logic        emit;
  status_e     emit_st;
  logic [15:0] emit_id;
  entry_t      emit_e;
  logic        emit_last;

  assign full = (count_q == CNT_W'(SLOTS));

  always_comb begin
    cur_x  = {{2{rdata_q.current[31]}}, rdata_q.current};
    del_x  = {3'b000, delta_q};
    sum_x  = cur_x + del_x;
    diff_x = cur_x - del_x;
    up_c   = (sum_x > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : sum_x[31:0];
    dn_c   = (diff_x < -34'sh0_8000_0000) ? 32'sh8000_0000 : diff_x[31:0];
    new_c  = rdata_q.down ? dn_c : up_c;
    fired  = rdata_q.enabled &&
             (rdata_q.down ? (dn_c <= rdata_q.target) : (up_c >= rdata_q.target));
    tick_e = rdata_q;
    if (rdata_q.enabled) begin
      tick_e.current = fired ? rdata_q.start : new_c;
    end
    report = fired && (fire_cnt_q < FIRE_W'(MAX_RESULTS));
    pend_d = tick_e;
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_idx_q[IDX_W-1:0];
    wdata = tick_e;
    if (cmd_i.tick_eval) begin
      // A fired one-shot entry is dropped; the later entries close up behind it.
      we = !(fired && rdata_q.one_shot);
    end else if (cmd_i.miss && kind_q == KIND_ADD && !full) begin
      we    = 1'b1;
      waddr = count_q[IDX_W-1:0];
      wdata = item_q;
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_st   = ST_NOT_FOUND;
    emit_id   = item_q.id;
    emit_e    = '0;
    emit_last = 1'b1;
    if (cmd_i.emit_hit) begin
      emit    = 1'b1;
      emit_st = (kind_q == KIND_ADD) ? ST_DUPLICATE : ST_FOUND;
      emit_id = rdata_q.id;
      emit_e  = rdata_q;
    end else if (cmd_i.miss) begin
      emit = 1'b1;
      if (kind_q == KIND_ADD) begin
        if (full) begin
          emit_st = ST_FULL;
        end else begin
          emit_st = ST_ADDED;
          emit_e  = item_q;
        end
      end
    end else if (cmd_i.tick_eval && report && pend_vld_q) begin
      emit      = 1'b1;
      emit_st   = ST_FIRED;
      emit_id   = pend_q.id;
      emit_e    = pend_q;
      emit_last = 1'b0;
    end else if (cmd_i.tick_end) begin
      emit = 1'b1;
      emit_id = 16'd0;
      if (pend_vld_q) begin
        emit_st = ST_FIRED;
        emit_id = pend_q.id;
        emit_e  = pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(kind_i);
      delta_q <= delta_i;
      item_q  <= '{id: timer_id_i, current: initial_value_i, start: start_value_i,
                   target: target_value_i, down: count_down_i, enabled: enabled_i,
                   one_shot: one_shot_i};
    end
    if (cmd_i.tick_eval && report) begin
      pend_q <= pend_d;
    end
    if (emit) begin
      status_o          <= emit_st;
      result_id_o       <= emit_id;
      result_current_o  <= emit_e.current;
      result_start_o    <= emit_e.start;
      result_target_o   <= emit_e.target;
      result_down_o     <= emit_e.down;
      result_enabled_o  <= emit_e.enabled;
      result_one_shot_o <= emit_e.one_shot;
      last_o            <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      fire_cnt_q <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= emit;
      if (cmd_i.load) begin
        rd_idx_q   <= '0;
        wr_idx_q   <= '0;
        fire_cnt_q <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.step) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (cmd_i.tick_eval) begin
        if (we) begin
          wr_idx_q <= wr_idx_q + CNT_W'(1);
        end
        if (report) begin
          pend_vld_q <= 1'b1;
          fire_cnt_q <= fire_cnt_q + FIRE_W'(1);
        end
      end
      if (cmd_i.tick_end) begin
        count_q <= wr_idx_q;
      end
      if (cmd_i.miss && kind_q == KIND_ADD && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign valid_o       = out_vld_q;
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.hit      = (rdata_q.id == item_q.id);
  assign sts_o.more     = ((rd_idx_q + CNT_W'(1)) < count_q);

endmodule

[hw/rtl/named_reload_timer_bank_unit.sv]
// Top level of the named reload timer bank.
// Depends on nrtb_pkg, nrtb_ctrl and nrtb_datapath.
//
// Usage: a command word (add, query or tick) is taken at a rising edge where
// start is high and busy is low. Results come out one per cycle in which valid_o
// is high, each word valid on the result ports in that cycle, with last_o set
// on the final word of the command. The receiver cannot stall the block.
// Add and query scan the table one entry at a time, reading and then comparing
// each, since the entry memory has one registered read port. A search stops at
// the first hit; a miss is reported once every timer held has been compared.
// A tick reads, updates and writes back each entry in turn, compacting out
// fired one-shot timers as it goes. Busy drops at the edge that takes the last
// word of a command. Up to eight fired timers are reported per tick. A reserved
// command kind is taken and dropped without any result. Reset empties the
// table at once; the entry memory itself is not cleared.
`timescale 1ns / 1ps
module named_reload_timer_bank_unit import nrtb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        timer_id_i,
  input  logic signed [31:0] initial_value_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] target_value_i,
  input  logic               count_down_i,
  input  logic               enabled_i,
  input  logic               one_shot_i,
  input  logic [30:0]        delta_i,
  output logic               valid_o,
  output logic [2:0]         status_o,
  output logic [15:0]        result_id_o,
  output logic signed [31:0] result_current_o,
  output logic signed [31:0] result_start_o,
  output logic signed [31:0] result_target_o,
  output logic               result_down_o,
  output logic               result_enabled_o,
  output logic               result_one_shot_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  nrtb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  nrtb_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .timer_id_i        (timer_id_i),
    .initial_value_i   (initial_value_i),
    .start_value_i     (start_value_i),
    .target_value_i    (target_value_i),
    .count_down_i      (count_down_i),
    .enabled_i         (enabled_i),
    .one_shot_i        (one_shot_i),
    .delta_i           (delta_i),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .result_id_o       (result_id_o),
    .result_current_o  (result_current_o),
    .result_start_o    (result_start_o),
    .result_target_o   (result_target_o),
    .result_down_o     (result_down_o),
    .result_enabled_o  (result_enabled_o),
    .result_one_shot_o (result_one_shot_o),
    .last_o            (last_o)
  );

endmodule

[tb/sv/tb_named_reload_timer_bank_unit.sv]
// Testbench for named_reload_timer_bank_unit: directed and random command words
// checked against an in-bench model of the timer table. Depends on nrtb_pkg.
`timescale 1ns / 1ps
module tb_named_reload_timer_bank_unit;
  import nrtb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] status;
    entry_t     ent;
    logic       last;
  } word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind_i = KIND_NONE;
  logic [15:0]        timer_id_i = '0;
  logic signed [31:0] initial_value_i = '0;
  logic signed [31:0] start_value_i = '0;
  logic signed [31:0] target_value_i = '0;
  logic               count_down_i = 1'b0;
  logic               enabled_i = 1'b0;
  logic               one_shot_i = 1'b0;
  logic [30:0]        delta_i = '0;
  logic               valid_o;
  logic [2:0]         status_o;
  logic [15:0]        result_id_o;
  logic signed [31:0] result_current_o;
  logic signed [31:0] result_start_o;
  logic signed [31:0] result_target_o;
  logic               result_down_o;
  logic               result_enabled_o;
  logic               result_one_shot_o;
  logic               last_o;

  entry_t timers [SLOTS_DEF];
  int     timers_used = 0;
  word_t  pending_words [$];
  int     mismatches = 0;
  int     cycles = 0;
  int     idle_pct = 0;

  always #4 clk_i = ~clk_i;

  named_reload_timer_bank_unit dut (.*);

  // Mirror of the timer table: works out the words one command produces.
  function automatic void model_command(logic [1:0] kind, entry_t item, logic [30:0] delta);
    word_t  w;
    int     hit;
    int     i;
    int     fires;
    logic   fired;
    longint c;
    hit = -1;
    for (int j = 0; j < timers_used; j++)
      if (hit < 0 && timers[j].id == item.id) hit = j;
    w = '0;
    w.last = 1'b1;
    w.ent.id = item.id;
    if (kind == KIND_ADD) begin
      if (hit >= 0) begin
        w.status = ST_DUPLICATE;
        w.ent = timers[hit];
      end else if (timers_used >= SLOTS_DEF) begin
        w.status = ST_FULL;
      end else begin
        timers[timers_used] = item;
        timers_used++;
        w.status = ST_ADDED;
        w.ent = item;
      end
      pending_words.push_back(w);
    end else if (kind == KIND_QUERY) begin
      if (hit >= 0) begin
        w.status = ST_FOUND;
        w.ent = timers[hit];
      end else begin
        w.status = ST_NOT_FOUND;
      end
      pending_words.push_back(w);
    end else if (kind == KIND_TICK) begin
      i = 0;
      fires = 0;
      while (i < timers_used) begin
        fired = 1'b0;
        if (timers[i].enabled) begin
          c = longint'(timers[i].current);
          if (timers[i].down) begin
            c = c - longint'(delta);
            if (c < -64'sd2147483648) c = -64'sd2147483648;
            fired = c <= longint'(timers[i].target);
          end else begin
            c = c + longint'(delta);
            if (c > 64'sd2147483647) c = 64'sd2147483647;
            fired = c >= longint'(timers[i].target);
          end
          timers[i].current = fired ? timers[i].start : c[31:0];
        end
        if (fired) begin
          if (fires < MAX_RESULTS) begin
            w = '0;
            w.status = ST_FIRED;
            w.ent = timers[i];
            pending_words.push_back(w);
            fires++;
          end
          if (timers[i].one_shot) begin
            // Close up the table; the entry moving in is handled in this tick.
            for (int j = i; j + 1 < timers_used; j++) timers[j] = timers[j + 1];
            timers_used--;
            continue;
          end
        end
        i++;
      end
      if (fires == 0) begin
        w = '0;
        w.status = ST_NOT_FOUND;
        w.last = 1'b1;
        pending_words.push_back(w);
      end else begin
        pending_words[$].last = 1'b1;
      end
    end
  endfunction

  // Outputs are sampled mid-cycle, away from the edge where they change.
  always @(negedge clk_i) begin
    word_t got;
    word_t want;
    if (rst_ni && valid_o) begin
      got.status = status_o;
      got.ent = '{result_id_o, result_current_o, result_start_o, result_target_o,
                  result_down_o, result_enabled_o, result_one_shot_o};
      got.last = last_o;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: status %0d id %h", got.status, got.ent.id);
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status || got.ent.id !== want.ent.id ||
            got.ent.current !== want.ent.current || got.ent.start !== want.ent.start ||
            got.ent.target !== want.ent.target || got.ent.down !== want.ent.down ||
            got.ent.enabled !== want.ent.enabled ||
            got.ent.one_shot !== want.ent.one_shot || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st %0d id %h cur %h sta %h tgt %h d%b e%b o%b l%b, got st %0d id %h cur %h sta %h tgt %h d%b e%b o%b l%b",
                     want.status, want.ent.id, want.ent.current, want.ent.start,
                     want.ent.target, want.ent.down, want.ent.enabled, want.ent.one_shot,
                     want.last, got.status, got.ent.id, got.ent.current, got.ent.start,
                     got.ent.target, got.ent.down, got.ent.enabled, got.ent.one_shot,
                     got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("named_reload_timer_bank_unit test failed");
      $finish;
    end
  end

  // Called just after a rising edge; returns once its word is taken and any idle gap.
  task automatic send_word(logic [1:0] kind, entry_t item, logic [30:0] delta);
    start <= 1'b1;
    kind_i <= kind;
    timer_id_i <= item.id;
    initial_value_i <= item.current;
    start_value_i <= item.start;
    target_value_i <= item.target;
    count_down_i <= item.down;
    enabled_i <= item.enabled;
    one_shot_i <= item.one_shot;
    delta_i <= delta;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    model_command(kind, item, delta);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS_DEF + 6) @(posedge clk_i);
  endtask

  function automatic entry_t mk(logic [15:0] id, logic [31:0] cur, logic [31:0] sta,
                                logic [31:0] tgt, logic dn, logic en, logic os);
    mk = '{id, cur, sta, tgt, dn, en, os};
  endfunction

  task automatic test_add_query_saturation();
    send_word(KIND_TICK, '0, 31'd5);
    send_word(KIND_ADD, mk(16'h0000, 32'h7FFF_FF00, 32'h0001_0000, 32'h7FFF_FFFF, 0, 1, 1), 0);
    send_word(KIND_ADD, mk(16'hFFFF, 32'h8000_0010, 32'hFFFF_FFFF, 32'h8000_0000, 1, 1, 1), 0);
    send_word(KIND_ADD, mk(16'hFFFF, 32'h1234_5678, 32'h0, 32'h0, 0, 0, 0), 0);
    send_word(KIND_ADD, mk(16'h00AA, 32'h0, 32'h0, 32'h0, 0, 0, 0), 0);
    send_word(KIND_QUERY, mk(16'h0000, 0, 0, 0, 0, 0, 0), 0);
    send_word(KIND_QUERY, mk(16'h1234, 0, 0, 0, 0, 0, 0), 0);
    send_word(KIND_NONE, mk(16'h0000, 32'hFFFF_FFFF, 0, 0, 1, 1, 1), 31'h7FFF_FFFF);
    // Both saturate and fire; the two one-shot timers go in a row.
    send_word(KIND_TICK, '0, 31'h7FFF_FFFF);
    send_word(KIND_QUERY, mk(16'h00AA, 0, 0, 0, 0, 0, 0), 0);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int k = 1; k < SLOTS_DEF; k++)
      send_word(KIND_ADD, mk(16'(k), 32'(k), 32'hFFFF_0000, 32'(k), k[0], 1, 1), 0);
    send_word(KIND_ADD, mk(16'h5555, 0, 0, 0, 0, 1, 0), 0);
    send_word(KIND_TICK, '0, 31'd0);
    send_word(KIND_TICK, '0, 31'd1);
    wait_drained();
  endtask

  task automatic random_item();
    entry_t      item;
    logic [30:0] delta;
    int          pick;
    item.id = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 11)) : 16'($urandom);
    if ($urandom_range(7) == 0) begin
      item.current = $urandom;
      item.start = $urandom;
      item.target = $urandom;
    end else begin
      item.current = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      item.start = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      item.target = item.current + 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
    end
    item.down = $urandom_range(1);
    item.enabled = $urandom_range(9) != 0;
    item.one_shot = $urandom_range(2) == 0;
    delta = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0003_0000));
    pick = $urandom_range(99);
    if (pick < 38) send_word(KIND_ADD, item, delta);
    else if (pick < 62) send_word(KIND_QUERY, item, delta);
    else if (pick < 96) send_word(KIND_TICK, item, delta);
    else send_word(KIND_NONE, item, delta);
  endtask

  task automatic test_random(int items, int pct);
    idle_pct = pct;
    repeat (items) random_item();
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_query_saturation();
    test_full_table();
    test_random(72, 0);
    test_random(72, 65);
    test_random(72, 12);
    test_random(72, 0);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("named_reload_timer_bank_unit test passed");
    end else begin
      $display("named_reload_timer_bank_unit test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/nrtb_pkg.sv
hw/rtl/nrtb_ctrl.sv
hw/rtl/nrtb_datapath.sv
hw/rtl/named_reload_timer_bank_unit.sv
tb/sv/tb_named_reload_timer_bank_unit.sv
